// File: rtl/utf8d_pkg.sv
// Shared types, constants and lead-byte helpers for the UTF-8 stream decoder.
package utf8d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_t;

  localparam int CpWidth    = 31;
  localparam int LenWidth   = 3;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [LenWidth-1:0] MaxLenReset = 3'd4;

  // One result item
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    status_t            status;
    logic               last_of_run;
  } result_t;

  // Results produced by one input transfer
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  // Sequence length from the lead byte; zero for bytes that cannot lead
  function automatic logic [LenWidth-1:0] lead_length(input logic [7:0] b);
    logic [LenWidth-1:0] len;
    len = 3'd0;
    case (b) inside
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  // Payload bits that a lead byte of the given length carries
  function automatic logic [7:0] lead_payload_mask(input logic [LenWidth-1:0] len);
    logic [7:0] mask;
    mask = 8'h00;
    case (len)
      3'd1:    mask = 8'h7f;
      3'd2:    mask = 8'h1f;
      3'd3:    mask = 8'h0f;
      3'd4:    mask = 8'h07;
      3'd5:    mask = 8'h03;
      3'd6:    mask = 8'h01;
      default: mask = 8'h00;
    endcase
    return mask;
  endfunction

endpackage

// File: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: decode step and result queue.
//
// Takes one byte per input transfer and returns one code point per completed
// UTF-8 sequence, with invalid and end-of-input reports. Each input transfer
// is decoded in the cycle it is accepted and its zero, one or two results
// land in a four-entry result queue, so a result is registered in the queue
// before it is offered. The block sustains one byte per cycle; in_ready
// drops only while the result queue holds more than two entries, which
// happens when the output side stalls or an end marker yields two results.
// The maximum sequence length (max_len) is written through cfg_we/cfg_wdata and resets to 4.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        end_marker,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic [1:0]  status,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);
  import utf8d_pkg::*;

  logic                fire;
  logic                pop;
  step_out_t           step_out;
  result_t             queue [QueueDepth];
  logic [QueueAw-1:0]  head;
  logic [QueueAw-1:0]  tail;
  logic [QueueAw:0]    count;
  logic [QueueAw:0]    push_n;
  result_t             head_entry;

  assign fire   = in_valid & in_ready;
  assign pop    = out_valid & out_ready;
  assign push_n = fire ? {{(QueueAw-1){1'b0}}, step_out.count} : '0;

  utf8d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .byte_value (byte_value),
    .end_marker (end_marker),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .step_out   (step_out)
  );

  // Accept a byte while room for two results remains
  assign in_ready = (count <= (QueueAw+1)'(QueueDepth - 2));

  // Store new results at the tail
  always_ff @(posedge clk) begin
    if (fire && step_out.count != 2'd0) begin
      queue[tail] <= step_out.first;
      if (step_out.count == 2'd2) begin
        queue[tail + QueueAw'(1)] <= step_out.second;
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push_n[QueueAw-1:0];
      if (pop) begin
        head <= head + QueueAw'(1);
      end
      count <= count + push_n - {{QueueAw{1'b0}}, pop};
    end
  end

  // Present the oldest result
  assign head_entry  = queue[head];
  assign out_valid   = (count != '0);
  assign code_point  = head_entry.code_point;
  assign status      = head_entry.status;
  assign last_of_run = head_entry.last_of_run;

endmodule

// File: rtl/utf8d_core.sv
// Sequence state and per-byte decode step of the UTF-8 stream decoder.
module utf8d_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_value,
  input  logic                end_marker,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  output utf8d_pkg::step_out_t step_out
);
  import utf8d_pkg::*;

  logic [LenWidth-1:0] max_len;
  logic [LenWidth-1:0] bytes_pending, bytes_pending_next;
  logic [CpWidth-1:0]  accumulator, accumulator_next;
  logic                sequence_bad, sequence_bad_next;
  logic                skipping, skipping_next;

  logic [LenWidth-1:0] len;
  logic [LenWidth-1:0] pend_dec;
  logic                cont_bad;
  logic [CpWidth-1:0]  acc_shift;

  assign len       = lead_length(byte_value);
  assign pend_dec  = bytes_pending - 3'd1;
  assign cont_bad  = (byte_value[7:6] != 2'b10);
  assign acc_shift = {accumulator[CpWidth-7:0], byte_value[5:0]};

  // Decode one byte against the current sequence state
  always_comb begin
    bytes_pending_next = bytes_pending;
    accumulator_next   = accumulator;
    sequence_bad_next  = sequence_bad;
    skipping_next      = skipping;
    step_out           = '0;
    step_out.first.status  = ST_VALID;
    step_out.second.status = ST_VALID;

    if (end_marker) begin
      // End of input: flush an open sequence as invalid, then report end
      if (bytes_pending != '0 && !skipping) begin
        step_out.count              = 2'd2;
        step_out.first.status       = ST_INVALID;
        step_out.second.status      = ST_END;
        step_out.second.last_of_run = 1'b1;
      end else begin
        step_out.count             = 2'd1;
        step_out.first.status      = ST_END;
        step_out.first.last_of_run = 1'b1;
      end
      bytes_pending_next = '0;
      accumulator_next   = '0;
      sequence_bad_next  = 1'b0;
      skipping_next      = 1'b0;
    end else if (bytes_pending != '0) begin
      bytes_pending_next = pend_dec;
      if (skipping) begin
        // Drop the byte; leave skip mode after the last one
        if (pend_dec == '0) begin
          skipping_next = 1'b0;
        end
      end else if (pend_dec != '0) begin
        sequence_bad_next = sequence_bad | cont_bad;
        accumulator_next  = acc_shift;
      end else begin
        // Final continuation byte closes the sequence
        step_out.count             = 2'd1;
        step_out.first.last_of_run = 1'b1;
        if (sequence_bad | cont_bad) begin
          step_out.first.status = ST_INVALID;
        end else begin
          step_out.first.code_point = acc_shift;
        end
        accumulator_next  = '0;
        sequence_bad_next = 1'b0;
      end
    end else begin
      step_out.count             = 2'd1;
      step_out.first.last_of_run = 1'b1;
      if (len == '0) begin
        step_out.first.status = ST_INVALID;
      end else if (len > max_len) begin
        // Lead too long: report now and swallow its trailing bytes
        step_out.first.status = ST_INVALID;
        bytes_pending_next    = len - 3'd1;
        skipping_next         = (len != 3'd1);
        accumulator_next      = '0;
        sequence_bad_next     = 1'b0;
      end else if (len == 3'd1) begin
        step_out.first.code_point = {{(CpWidth-8){1'b0}}, byte_value};
      end else begin
        // Open a multi-byte sequence
        step_out.count             = 2'd0;
        step_out.first.last_of_run = 1'b0;
        accumulator_next   = {{(CpWidth-8){1'b0}}, byte_value & lead_payload_mask(len)};
        bytes_pending_next = len - 3'd1;
        sequence_bad_next  = 1'b0;
        skipping_next      = 1'b0;
      end
    end
  end

  // Advance sequence state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      accumulator   <= '0;
      sequence_bad  <= 1'b0;
      skipping      <= 1'b0;
    end else if (fire) begin
      bytes_pending <= bytes_pending_next;
      accumulator   <= accumulator_next;
      sequence_bad  <= sequence_bad_next;
      skipping      <= skipping_next;
    end
  end

  // Hold the configured maximum sequence length
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MaxLenReset;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

endmodule
